@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/lud_pkg.sv @@
// Package: types, constants and helper functions of the UTF-8 decoder.
`default_nettype none
package lud_pkg;

  localparam int CP_W            = 21;
  localparam int POS_W           = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int SLOTS           = 4;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] LEAD_MASK = 8'h7F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  char_code;
    logic [2:0]       bytes_used;
    logic             is_space;
    logic             in_leading_space;
    logic [POS_W-1:0] position;
    logic             final_res;
  } out_item_t;

  // One pending result from the decode front.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [2:0]      used;
    logic            fin;
  } slot_t;

  // All results caused by one byte, slot 0 first.
  typedef struct packed {
    slot_t [SLOTS-1:0] slot;
    logic [2:0]        count;
  } burst_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b >= LEAD4)      len = 3'd4;
    else if (b >= LEAD3) len = 3'd3;
    else if (b >= LEAD2) len = 3'd2;
    else                 len = 3'd1;
    return len;
  endfunction

  // Unicode White_Space set.
  function automatic logic is_white(input logic [CP_W-1:0] cp);
    return (cp >= 21'h0009 && cp <= 21'h000D) || cp == 21'h0020 || cp == 21'h0085 ||
           cp == 21'h00A0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
           cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F ||
           cp == 21'h3000;
  endfunction

endpackage
`default_nettype wire

@@ sv/lud_front.sv @@
// Decode front: sequence assembly and result burst build for each byte.
`default_nettype none
module lud_front import lud_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire in_item_t byte_data,
  input  wire logic     q_full,
  output logic          push,
  output burst_t        burst
);

  logic [7:0]      lead_byte, lead_byte_next;
  logic [2:0]      expected_len, expected_len_next;
  logic [1:0]      held_count, held_count_next;
  logic [7:0]      held_bytes [2];
  logic [7:0]      held_bytes_next [2];
  logic [CP_W-1:0] partial_value, partial_value_next;

  logic [7:0]      b;
  logic            eot, pend, cont, accept;
  logic [2:0]      fresh_len;
  logic [1:0]      fresh_pos;
  logic [CP_W-1:0] new_pv;
  logic [7:0]      raw_src [3];

  assign b          = byte_data.in_byte;
  assign eot        = byte_data.end_of_text;
  assign pend       = (expected_len != 3'd0);
  assign cont       = ((b & CONT_MASK) == CONT_TAG);
  assign fresh_len  = seq_len(b);
  assign new_pv     = {partial_value[CP_W-7:0], b[5:0]};
  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign raw_src[0] = lead_byte;
  assign raw_src[1] = held_bytes[0];
  assign raw_src[2] = held_bytes[1];

  always_comb begin
    burst              = '0;
    fresh_pos          = 2'd0;
    lead_byte_next     = lead_byte;
    expected_len_next  = expected_len;
    held_count_next    = held_count;
    held_bytes_next    = held_bytes;
    partial_value_next = partial_value;
    if (pend && cont) begin
      if (({1'b0, held_count} + 3'd2) >= expected_len) begin
        burst.slot[0].cp   = new_pv;
        burst.slot[0].used = expected_len;
        burst.slot[0].fin  = eot;
        burst.count        = 3'd1;
        expected_len_next  = 3'd0;
      end else if (eot) begin
        // cut off at end of text: everything goes out raw
        for (int i = 0; i < 3; i++) begin
          if (i <= int'(held_count)) begin
            burst.slot[i].cp   = {13'd0, raw_src[i]};
            burst.slot[i].used = 3'd1;
          end
        end
        fresh_pos                  = held_count + 2'd1;
        burst.slot[fresh_pos].cp   = {13'd0, b};
        burst.slot[fresh_pos].used = 3'd1;
        burst.slot[fresh_pos].fin  = 1'b1;
        burst.count                = {1'b0, fresh_pos} + 3'd1;
        expected_len_next          = 3'd0;
      end else begin
        held_bytes_next[held_count[0]] = b;
        held_count_next                = held_count + 2'd1;
        partial_value_next             = new_pv;
      end
    end else begin
      if (pend) begin
        // broken sequence: lead and held bytes go out raw first
        for (int i = 0; i < 3; i++) begin
          if (i <= int'(held_count)) begin
            burst.slot[i].cp   = {13'd0, raw_src[i]};
            burst.slot[i].used = 3'd1;
          end
        end
        fresh_pos         = held_count + 2'd1;
        burst.count       = {1'b0, fresh_pos};
        expected_len_next = 3'd0;
      end
      if (fresh_len == 3'd1 || eot) begin
        burst.slot[fresh_pos].cp   = {13'd0, b};
        burst.slot[fresh_pos].used = 3'd1;
        burst.slot[fresh_pos].fin  = eot;
        burst.count                = {1'b0, fresh_pos} + 3'd1;
      end else begin
        lead_byte_next     = b;
        expected_len_next  = fresh_len;
        held_count_next    = 2'd0;
        partial_value_next = {13'd0, b & (LEAD_MASK >> fresh_len)};
      end
    end
    if (eot || expected_len_next == 3'd0) begin
      expected_len_next = 3'd0;
      held_count_next   = 2'd0;
    end
  end

  assign push = accept && (burst.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= 3'd0;
      held_count   <= 2'd0;
    end else if (accept) begin
      expected_len <= expected_len_next;
      held_count   <= held_count_next;
    end
  end

  // sequence payload, qualified by expected_len
  always_ff @(posedge clk) begin
    if (accept) begin
      lead_byte     <= lead_byte_next;
      held_bytes    <= held_bytes_next;
      partial_value <= partial_value_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/lud_queue.sv @@
// Short queue of result bursts between decode front and emit back.
`default_nettype none
module lud_queue import lud_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire burst_t push_data,
  input  wire logic   pop,
  output q_status_t   status,
  output burst_t      head
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  burst_t          mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign status.empty = (fill == CntW'(0));
  assign status.full  = (fill == CntW'(QUEUE_DEPTH));
  assign head         = mem[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      fill <= fill + CntW'(1);
      else if (pop && !push) fill <= fill - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

@@ sv/lud_back.sv @@
// Emit back: one result per cycle while not stalled, whitespace flags and running index.
`default_nettype none
module lud_back import lud_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t status,
  input  wire burst_t    head,
  output logic           pop,
  output logic           cp_valid,
  input  wire logic      cp_ready,
  output out_item_t      cp_data
);

  localparam int CntW = (COUNT_WIDTH > POS_W) ? POS_W : COUNT_WIDTH;

  logic [1:0]      idx;
  logic            leading_flag;
  logic [CntW-1:0] cp_counter;

  slot_t cur;
  logic  load, last, sp, lf;

  assign load = !status.empty && (!cp_valid || cp_ready);
  assign cur  = head.slot[idx];
  assign sp   = is_white(cur.cp);
  assign lf   = leading_flag && sp;
  assign last = (({1'b0, idx} + 3'd1) == head.count);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= 2'd0;
      leading_flag <= 1'b1;
      cp_counter   <= '0;
      cp_valid     <= 1'b0;
    end else begin
      if (load) begin
        cp_valid <= 1'b1;
        idx      <= last ? 2'd0 : idx + 2'd1;
        if (cur.fin) begin
          leading_flag <= 1'b1;
          cp_counter   <= '0;
        end else begin
          leading_flag <= lf;
          if (cp_counter != '1) cp_counter <= cp_counter + CntW'(1);
        end
      end else if (cp_ready) begin
        cp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_data.char_code        <= cur.cp;
      cp_data.bytes_used       <= cur.used;
      cp_data.is_space         <= sp;
      cp_data.in_leading_space <= lf;
      cp_data.position         <= POS_W'(cp_counter);
      cp_data.final_res        <= cur.fin;
    end
  end

endmodule
`default_nettype wire

@@ sv/lenient_utf8_decoder_top.sv @@
// Top level of the lenient UTF-8 decoder: front, burst queue and emit back.
//
//   channel    direction  handshake               payload
//   byte_*     in         byte_valid/byte_ready   in_item_t  (byte, end of text)
//   cp_*       out        cp_valid/cp_ready       out_item_t (code point and flags)
//
// One byte is taken per cycle while the burst queue has room; a byte that
// completes a character or is plain ASCII leaves one result, which passes
// through the burst queue and the output register to cp_*.
// A broken or cut-off sequence leaves a burst of up to four results, which the
// back drains at one per cycle while cp_ready is high.
// Reset (rst, synchronous) drops any pending sequence, empties the queue, sets
// the leading-whitespace flag and zeroes the index. Either side may stall on its
// own: the queue holds two bursts and the output register holds one result.
`default_nettype none
module lenient_utf8_decoder_top import lud_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire in_item_t byte_data,
  output logic          cp_valid,
  input  wire logic     cp_ready,
  output out_item_t     cp_data
);

  // front to queue
  logic      push;
  burst_t    burst;
  // queue to back
  q_status_t status;
  burst_t    head;
  logic      pop;

  // Front: classifies each byte against the pending sequence and builds the
  // whole burst of results that byte causes.
  lud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_full     (status.full),
    .push       (push),
    .burst      (burst)
  );

  // Queue: decouples byte intake from result delivery.
  lud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .status    (status),
    .head      (head)
  );

  // Back: walks a burst slot by slot, adds whitespace state and the index.
  lud_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .head     (head),
    .pop      (pop),
    .cp_valid (cp_valid),
    .cp_ready (cp_ready),
    .cp_data  (cp_data)
  );

endmodule
`default_nettype wire

@@ sv/lud_checker.sv @@
// Port-level checker for the UTF-8 decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lud_checker import lud_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      cp_valid,
  input wire logic      cp_ready,
  input wire out_item_t cp_data
);

  localparam logic [POS_W-1:0] CntMax = (COUNT_WIDTH >= POS_W) ? '1 :
                                        POS_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic             seen, prev_final;
  logic [POS_W-1:0] prev_pos;
  logic             out_acc;
  logic             raw_out;
  logic             pos_step_ok;

  assign out_acc     = cp_valid && cp_ready;
  assign raw_out     = cp_valid && (cp_data.bytes_used == 3'd1);
  assign pos_step_ok = (prev_pos == CntMax) ? (cp_data.position == CntMax) :
                                              (cp_data.position == prev_pos + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      prev_final <= 1'b0;
      prev_pos   <= '0;
    end else if (out_acc) begin
      seen       <= 1'b1;
      prev_final <= cp_data.final_res;
      prev_pos   <= cp_data.position;
    end
  end

  `ASSERT_NXT(a_stall_hold, clk, rst, cp_valid && !cp_ready, cp_valid && $stable(cp_data))
  `ASSERT_IMP(a_lead_ws, clk, rst, cp_valid && cp_data.in_leading_space, cp_data.is_space)
  `ASSERT_IMP(a_raw_byte, clk, rst, raw_out, cp_data.char_code <= 21'd255)
  `ASSERT_IMP(a_new_text, clk, rst, out_acc && (!seen || prev_final), cp_data.position == '0)
  `ASSERT_IMP(a_index_step, clk, rst, out_acc && seen && !prev_final, pos_step_ok)

endmodule

bind lenient_utf8_decoder_top lud_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_lud_checker (
  .clk      (clk),
  .rst      (rst),
  .cp_valid (cp_valid),
  .cp_ready (cp_ready),
  .cp_data  (cp_data)
);
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the lenient UTF-8 decoder: byte stimulus, code point scoreboard.
`default_nettype none
module tb_top import lud_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stall styles, changed segment by segment.
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC} rx_style_t;

  localparam int RANDOM_BYTES  = 195;
  localparam int HOLD_AFTER    = 40;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 60;
  localparam int TAIL_CYCLES   = 16;

  // White_Space members first, then near misses around them.
  localparam int WS_COUNT = 13;
  localparam logic [20:0] SPACE_CPS [20] = '{
    21'h0009, 21'h000D, 21'h0020, 21'h0085, 21'h00A0, 21'h1680, 21'h2000,
    21'h200A, 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000,
    21'h0008, 21'h000E, 21'h0021, 21'h1FFF, 21'h200B, 21'h202A, 21'h3001
  };

  // ---------------------------------------------------------------------------
  // Scoreboard: decodes every accepted byte request into the code points it
  // should cause, and checks the block's results against them in order.
  // ---------------------------------------------------------------------------
  class cp_scoreboard;
    logic [7:0]  lead;
    logic [2:0]  want_len;     // 0: no sequence pending
    logic [1:0]  held_n;
    logic [7:0]  held [2];
    logic [20:0] acc;
    bit          all_white;
    logic [31:0] cp_index;
    out_item_t   expected_cps[$];
    int          step_n;
    int          errors, requests, texts, results_checked, bursts, widest, lead_space_cps;

    function new();
      clear_seq();
      all_white = 1'b1;
      cp_index  = '0;
    endfunction

    function void clear_seq();
      lead     = '0;
      want_len = '0;
      held_n   = '0;
      held[0]  = '0;
      held[1]  = '0;
      acc      = '0;
    endfunction

    function bit ws_member(logic [20:0] cp);
      foreach (SPACE_CPS[i])
        if (i < WS_COUNT && cp == SPACE_CPS[i]) return 1'b1;
      return (cp >= 21'h0009 && cp <= 21'h000D) || (cp >= 21'h2000 && cp <= 21'h200A);
    endfunction

    function void queue_cp(logic [20:0] cp, logic [2:0] used, bit fin);
      out_item_t e;
      bit sp;
      if (step_n >= 4) return;
      sp = ws_member(cp);
      all_white = all_white & sp;
      e.char_code        = cp;
      e.bytes_used       = used;
      e.is_space         = sp;
      e.in_leading_space = all_white;
      e.position         = cp_index;
      e.final_res        = fin;
      expected_cps.push_back(e);
      if (cp_index != 32'hFFFF_FFFF) cp_index++;
      step_n++;
    endfunction

    // Broken sequence: lead and held bytes go out raw, one each.
    function void dump_seq();
      queue_cp({13'd0, lead}, 3'd1, 1'b0);
      for (int i = 0; i < held_n; i++) queue_cp({13'd0, held[i]}, 3'd1, 1'b0);
    endfunction

    function void decode_request(in_item_t req);
      logic [7:0] b;
      logic [2:0] n;
      bit eot, taken;
      b      = req.in_byte;
      eot    = req.end_of_text;
      taken  = 1'b0;
      step_n = 0;
      requests++;
      if (want_len != 0) begin
        if (b[7:6] == 2'b10) begin
          acc = {acc[14:0], b[5:0]};
          if (held_n + 2 >= want_len) begin
            queue_cp(acc, want_len, eot);
            clear_seq();
          end else if (eot) begin
            // cut off at end of text
            dump_seq();
            queue_cp({13'd0, b}, 3'd1, 1'b1);
            clear_seq();
          end else begin
            held[held_n[0]] = b;
            held_n++;
          end
          taken = 1'b1;
        end else begin
          dump_seq();
          clear_seq();
        end
      end
      if (!taken) begin
        if (b < 8'h80)       n = 3'd1;
        else if (b >= 8'hF0) n = 3'd4;
        else if (b >= 8'hE0) n = 3'd3;
        else if (b >= 8'hC0) n = 3'd2;
        else                 n = 3'd1;   // stray continuation
        if (n == 3'd1 || eot) begin
          queue_cp({13'd0, b}, 3'd1, eot);
        end else begin
          lead     = b;
          want_len = n;
          held_n   = '0;
          acc      = {13'd0, b & (8'h7F >> n)};
        end
      end
      if (eot) begin
        clear_seq();
        all_white = 1'b1;
        cp_index  = '0;
        texts++;
      end
      if (step_n > 1) bursts++;
      if (step_n > widest) widest = step_n;
    endfunction

    function void flag_field(string name, logic [31:0] pos, logic [31:0] want,
                             logic [31:0] seen);
      $display("%0t: %s mismatch at index %0d: expected %0h, actual %0h",
               $time, name, pos, want, seen);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results_checked++;
      if (expected_cps.size() == 0) begin
        $display("%0t: unexpected code point: expected none, actual %0h", $time,
                 got.char_code);
        errors++;
        return;
      end
      e = expected_cps.pop_front();
      if (e.in_leading_space) lead_space_cps++;
      if (got.char_code !== e.char_code)
        flag_field("char_code", e.position, e.char_code, got.char_code);
      if (got.bytes_used !== e.bytes_used)
        flag_field("bytes_used", e.position, e.bytes_used, got.bytes_used);
      if (got.is_space !== e.is_space)
        flag_field("is_space", e.position, e.is_space, got.is_space);
      if (got.in_leading_space !== e.in_leading_space)
        flag_field("in_leading_space", e.position, e.in_leading_space, got.in_leading_space);
      if (got.position !== e.position)
        flag_field("position", e.position, e.position, got.position);
      if (got.final_res !== e.final_res)
        flag_field("final_res", e.position, e.final_res, got.final_res);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst;
  logic      byte_valid;
  logic      byte_ready;
  in_item_t  byte_data;
  logic      cp_valid;
  logic      cp_ready;
  out_item_t cp_data;

  cp_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lenient_utf8_decoder_top u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .cp_valid   (cp_valid),
    .cp_ready   (cp_ready),
    .cp_data    (cp_data)
  );

  // ---------------------------------------------------------------------------
  // Stimulus build: byte requests collected up front, then driven in bursts.
  // ---------------------------------------------------------------------------
  in_item_t   stim_q[$];
  logic [7:0] text_buf[$];
  int         random_items;

  function automatic void push_byte(logic [7:0] b, bit eot);
    in_item_t it;
    it.in_byte     = b;
    it.end_of_text = eot;
    stim_q.push_back(it);
  endfunction

  // Encodes cp in len bytes (overlong allowed) and keeps the first keep of them.
  function automatic void encode_cp(logic [20:0] cp, int len, int keep);
    logic [7:0] seq [4];
    seq = '{default: 8'h00};
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) text_buf.push_back(seq[i]);
  endfunction

  function automatic void add_directed();
    // leading whitespace: space, NBSP in two bytes, LINE SEPARATOR in three
    push_byte(8'h20, 1'b0);
    push_byte(8'hC2, 1'b0); push_byte(8'hA0, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'hA8, 1'b0);
    // lowest and highest ASCII, then a stray continuation byte
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    // four-byte emoji, then an 0xFF lead with all payload bits set
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // 0xF8 lead with two held bytes broken by a new lead: a burst of three raw
    push_byte(8'hF8, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hC3, 1'b0); push_byte(8'hA9, 1'b1);
    // sequence cut off by end of text
    push_byte(8'hE2, 1'b0); push_byte(8'h80, 1'b1);
    // lead byte as the whole text
    push_byte(8'hC5, 1'b1);
  endfunction

  function automatic void add_text();
    int n_chars, lead_ws, kind, len, keep, bits;
    logic [20:0] cp;
    n_chars = $urandom_range(1, 10);
    lead_ws = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n_chars) : 0;
    text_buf.delete();
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(0, 99);
      if (c < lead_ws || kind < 15) begin
        cp  = (c < lead_ws) ? SPACE_CPS[$urandom_range(0, WS_COUNT - 1)]
                            : SPACE_CPS[$urandom_range(0, $size(SPACE_CPS) - 1)];
        len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : 3;
        encode_cp(cp, len, len);
      end else if (kind < 28) begin
        text_buf.push_back(8'($urandom_range(0, 255)));   // noise
      end else begin
        len  = $urandom_range(1, 4);
        bits = (len == 1) ? 7 : (len == 2) ? 11 : (len == 3) ? 16 : 21;
        cp   = 21'($urandom & ((32'd1 << bits) - 32'd1));
        keep = (kind < 42 && len > 1) ? $urandom_range(1, len - 1) : len;
        encode_cp(cp, len, keep);
        if (len == 4 && $urandom_range(0, 7) == 0)
          text_buf[text_buf.size() - keep] = 8'hF8 | 8'($urandom_range(0, 7));
      end
    end
    foreach (text_buf[i]) push_byte(text_buf[i], i == text_buf.size() - 1);
    random_items += text_buf.size();
  endfunction

  // One byte request: raised at a falling edge, held until taken.
  task automatic send_request(input in_item_t req);
    byte_valid <= 1'b1;
    byte_data  <= req;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.decode_request(req);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; junk on the bus when idle.
  // ---------------------------------------------------------------------------
  initial begin : tx_side
    int idx, burst, gap;
    in_item_t junk;
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_data  = '0;
    add_directed();
    random_items = 0;
    while (random_items < RANDOM_BYTES) add_text();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && idx < stim_q.size()) begin
        send_request(stim_q[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        junk.in_byte     = 8'($urandom_range(0, 255));
        junk.end_of_text = 1'($urandom_range(0, 1));
        byte_valid <= 1'b0;
        byte_data  <= junk;
        repeat (gap) @(negedge clk);
      end
    end
    byte_valid <= 1'b0;
    // drain: wait for every expected code point, then a quiet tail
    while (sb.expected_cps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d byte requests in %0d texts; %0d code points checked.",
             sb.requests, sb.texts, sb.results_checked);
    $display("Multi-result bursts: %0d (widest %0d); leading-whitespace results: %0d.",
             sb.bursts, sb.widest, sb.lead_space_cps);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes by segment; one long hold-off so the queue
  // fills and the input side has to back off.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    rx_style_t style;
    int seg_left, period, tick, hold_left;
    bit hold_done;
    cp_ready  = 1'b0;
    style     = RX_OPEN;
    seg_left  = 0;
    period    = 2;
    tick      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (seg_left == 0) begin
        style    = rx_style_t'($urandom_range(0, 2));
        period   = $urandom_range(2, 5);
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        cp_ready <= 1'b0;
      end else begin
        case (style)
          RX_OPEN:  cp_ready <= 1'b1;
          RX_COIN:  cp_ready <= 1'($urandom_range(0, 1));
          default:  cp_ready <= (tick % period) != 0;
        endcase
      end
    end
  end

  // Results are taken at the rising edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && cp_valid && cp_ready) sb.check_result(cp_data);
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d code points still expected", sb.expected_cps.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/lud_pkg.sv
sv/lud_front.sv
sv/lud_queue.sv
sv/lud_back.sv
sv/lenient_utf8_decoder_top.sv
sv/lud_checker.sv
verif/tb_top.sv
